FILE: hdl/http_request_header_parser_top_macros.svh
// Assertion macros shared by the checker of the header parser.
// Depends on nothing; included by the checker file.
`ifndef HTTP_REQUEST_HEADER_PARSER_TOP_MACROS_SVH
`define HTTP_REQUEST_HEADER_PARSER_TOP_MACROS_SVH
// Assert an implication on every clock edge outside reset.
`define HRP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert an implication in the following cycle outside reset.
`define HRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hdl/hrp_pkg.sv
// Shared types and constants of the HTTP request header parser.
// No dependencies.
package hrp_pkg;
  localparam int unsigned MaxPayload = 65535;
  localparam int unsigned PosW = 16;

  localparam logic [2:0] K_URI    = 3'd0;
  localparam logic [2:0] K_HOST   = 3'd1;
  localparam logic [2:0] K_UA     = 3'd2;
  localparam logic [2:0] K_REF    = 3'd3;
  localparam logic [2:0] K_COOKIE = 3'd4;
  localparam logic [2:0] K_CLEN   = 3'd5;
  localparam logic [2:0] K_DONE   = 3'd6;

  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_EARLY   = 4'd1;
  localparam logic [3:0] ST_FIRST   = 4'd2;
  localparam logic [3:0] ST_METHOD  = 4'd3;
  localparam logic [3:0] ST_MCHAR   = 4'd4;
  localparam logic [3:0] ST_PREURI  = 4'd5;
  localparam logic [3:0] ST_URICR   = 4'd6;
  localparam logic [3:0] ST_URILF   = 4'd7;
  localparam logic [3:0] ST_AFTURI  = 4'd8;
  localparam logic [3:0] ST_NOKIND  = 4'd9;
  localparam logic [3:0] ST_BLANK   = 4'd10;
  localparam logic [3:0] ST_TOOLONG = 4'd11;

  // One result item: 16+16+16 data bits and 9 tuser bits; tlast carried apart.
  typedef struct packed {
    logic [2:0]  item_kind;
    logic [15:0] span_start;
    logic [15:0] span_end;
    logic        to_payload_end;
    logic [3:0]  status;
    logic        is_post;
    logic [15:0] body_offset;
  } res_t;

  // What the front hands to the back for one byte: up to two results.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } cmd_t;
endpackage

FILE: hdl/hrp_front.sv
// Front: parses one byte per cycle while the queue is ready and emits a command of up to two results.
// Depends on hrp_pkg.
module hrp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         byte_i,
  input  logic               first_i,
  input  logic               last_i,
  input  logic               q_ready,
  output logic               q_valid,
  output hrp_pkg::cmd_t      q_cmd
);
  import hrp_pkg::*;

  localparam logic [3:0] S_START = 4'd0, S_METHOD = 4'd1, S_SP_URI = 4'd2,
    S_URI = 4'd3, S_AFTER_URI = 4'd4, S_LINE_END = 4'd5, S_HEAD = 4'd6,
    S_NAME = 4'd7, S_SP_VAL = 4'd8, S_VAL = 4'd9, S_IGNORE = 4'd10,
    S_ALMOST = 4'd11;
  localparam logic [7:0] CR = 8'd13, LF = 8'd10, SP = 8'h20;

  logic [3:0]  state_r, state_nxt;
  logic [15:0] pos_r, pos_nxt, mark_r, mark_nxt, uri_r, uri_nxt;
  logic [47:0] pfx_r, pfx_nxt;
  logic [2:0]  hk_r, hk_nxt;
  logic        post_r, post_nxt, act_r, act_nxt;

  logic        acc;
  logic [3:0]  st_c;
  logic [15:0] p, len, k;
  logic        done, emit0, last_two;
  res_t        span, dn;
  logic [47:0] pfx_app, pfx_b;

  assign in_tready = q_ready;
  assign acc = in_tvalid && in_tready;

  always_comb begin
    // start from state, restart on first byte
    state_nxt = first_i ? S_START : state_r;
    pos_nxt   = first_i ? '0 : pos_r;
    mark_nxt  = first_i ? '0 : mark_r;
    uri_nxt   = first_i ? '0 : uri_r;
    pfx_b     = first_i ? '0 : pfx_r;
    pfx_nxt   = pfx_b;
    hk_nxt    = first_i ? K_URI : hk_r;
    post_nxt  = first_i ? 1'b0 : post_r;
    act_nxt   = first_i ? 1'b1 : act_r;
    p = pos_nxt;
    len = p - mark_nxt;
    k = len;
    pfx_app = pfx_b;
    if (k < 16'd6) pfx_app = pfx_b | ({40'd0, byte_i} << {k[2:0], 3'b000});
    done = 1'b0; st_c = ST_OK; emit0 = 1'b0;
    span = '0;
    dn = '0;
    if (act_nxt) begin
      if (p >= 16'(MaxPayload)) begin
        done = 1'b1; st_c = ST_TOOLONG;
      end else if (byte_i == 8'd0) begin
        done = 1'b1; st_c = ST_EARLY;
      end else begin
        unique case (state_nxt)
          S_START: begin
            mark_nxt = p;
            if (byte_i == CR || byte_i == LF) begin
            end else if (byte_i < "A" || byte_i > "Z") begin
              done = 1'b1; st_c = ST_FIRST;
            end else begin
              pfx_nxt = {40'd0, byte_i}; state_nxt = S_METHOD;
            end
          end
          S_METHOD: begin
            if (byte_i == SP) begin
              if (len == 16'd3 && pfx_b[23:0] == "TEG") state_nxt = S_SP_URI;
              else if (len == 16'd4 && pfx_b[31:0] == "TSOP") begin
                post_nxt = 1'b1; state_nxt = S_SP_URI;
              end else begin
                done = 1'b1; st_c = ST_METHOD;
              end
            end else if (byte_i < "A" || byte_i > "Z") begin
              done = 1'b1; st_c = ST_MCHAR;
            end else pfx_nxt = pfx_app;
          end
          S_SP_URI: begin
            if (byte_i == "/") begin
              uri_nxt = p; mark_nxt = p; state_nxt = S_URI;
            end else if (byte_i != SP) begin
              done = 1'b1; st_c = ST_PREURI;
            end
          end
          S_URI: begin
            if (byte_i == SP) begin
              emit0 = 1'b1; span.item_kind = K_URI;
              span.span_start = uri_nxt; span.span_end = p - 16'd1;
              state_nxt = S_AFTER_URI;
            end else if (byte_i == CR) begin
              done = 1'b1; st_c = ST_URICR;
            end else if (byte_i == LF) begin
              done = 1'b1; st_c = ST_URILF;
            end
          end
          S_AFTER_URI: begin
            if (byte_i == SP) begin
            end else if (byte_i == CR || byte_i == LF) begin
              done = 1'b1; st_c = ST_AFTURI;
            end else state_nxt = (byte_i == "H") ? S_LINE_END : S_URI;
          end
          S_LINE_END: if (byte_i == LF) state_nxt = S_HEAD;
          S_HEAD: begin
            if (byte_i == SP) begin
            end else if (byte_i == CR) state_nxt = S_ALMOST;
            else if (byte_i == LF) begin
              done = 1'b1; st_c = ST_OK; dn.body_offset = p + 16'd1;
            end else begin
              mark_nxt = p; pfx_nxt = {40'd0, byte_i}; state_nxt = S_NAME;
            end
          end
          S_NAME: begin
            if (byte_i != SP && byte_i != ":") pfx_nxt = pfx_app;
            else begin
              state_nxt = S_SP_VAL;
              if (len == 16'd4 && pfx_b[31:0] == "tsoH") hk_nxt = K_HOST;
              else if (len == 16'd6 && pfx_b == "eikooC") begin
                hk_nxt = K_COOKIE; emit0 = 1'b1;
                span.item_kind = K_COOKIE; span.span_start = p + 16'd1;
                span.to_payload_end = 1'b1;
              end else if (len == 16'd7 && pfx_b[39:0] == "refeR") hk_nxt = K_REF;
              else if (len == 16'd10 && pfx_b[39:0] == "-resU") hk_nxt = K_UA;
              else if (len == 16'd14 && pfx_b[39:0] == "etnoC") hk_nxt = K_CLEN;
              else state_nxt = S_IGNORE;
            end
          end
          S_SP_VAL: begin
            if (byte_i != ":" && byte_i != SP) begin
              mark_nxt = p; state_nxt = S_VAL;
            end
          end
          S_VAL: begin
            if (byte_i == CR) begin
              if (hk_nxt >= K_HOST && hk_nxt <= K_CLEN) begin
                emit0 = 1'b1; span.item_kind = hk_nxt;
                span.span_start = mark_nxt; span.span_end = p - 16'd1;
              end else begin
                done = 1'b1; st_c = ST_NOKIND;
              end
            end else if (byte_i == LF) state_nxt = S_HEAD;
          end
          S_IGNORE: if (byte_i == LF) state_nxt = S_HEAD;
          S_ALMOST: begin
            if (byte_i == LF) begin
              done = 1'b1; st_c = ST_OK; dn.body_offset = p + 16'd1;
            end else if (byte_i != CR) begin
              done = 1'b1; st_c = ST_BLANK;
            end
          end
          default: begin
            done = 1'b1; st_c = ST_NOKIND;
          end
        endcase
        pos_nxt = p + 16'd1;
      end
      if (!done && last_i) begin
        done = 1'b1; st_c = ST_EARLY;
      end
      if (done) begin
        act_nxt = 1'b0; state_nxt = S_START;
      end
    end
    dn.item_kind = K_DONE;
    dn.status = st_c;
    dn.is_post = post_nxt;
    if (st_c != ST_OK) dn.body_offset = '0;
    last_two = emit0 && done;
    q_cmd.two = last_two;
    q_cmd.r0 = emit0 ? span : dn;
    q_cmd.r1 = dn;
    q_valid = in_tvalid && (emit0 || done);
  end

  // advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START; pos_r <= '0; mark_r <= '0; uri_r <= '0;
      pfx_r <= '0; hk_r <= K_URI; post_r <= 1'b0; act_r <= 1'b0;
    end else if (acc) begin
      state_r <= state_nxt; pos_r <= pos_nxt; mark_r <= mark_nxt;
      uri_r <= uri_nxt; pfx_r <= pfx_nxt; hk_r <= hk_nxt;
      post_r <= post_nxt; act_r <= act_nxt;
    end
  end
endmodule

FILE: hdl/hrp_back.sv
// Back: two-entry command queue and output stage that splits commands into beats.
// Depends on hrp_pkg.
module hrp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  hrp_pkg::cmd_t  q_cmd,
  output logic           out_tvalid,
  input  logic           out_tready,
  output hrp_pkg::res_t  res_o,
  output logic           last_o
);
  import hrp_pkg::*;

  cmd_t       ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic       sub_r, sub_nxt;
  logic       push, pop;
  cmd_t       head;

  assign head = ent_r[rd_r];
  assign q_ready = (cnt_r != 2'd2);
  assign push = q_valid && q_ready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign res_o = sub_r ? head.r1 : head.r0;
  assign last_o = sub_r || !head.two;
  assign pop = out_tvalid && out_tready && last_o;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    rd_nxt = pop ? ~rd_r : rd_r;
    wr_nxt = push ? ~wr_r : wr_r;
    sub_nxt = sub_r;
    if (out_tvalid && out_tready) sub_nxt = !last_o;
  end

  // store commands
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= q_cmd;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0; sub_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; rd_r <= rd_nxt; wr_r <= wr_nxt; sub_r <= sub_nxt;
    end
  end
endmodule

FILE: hdl/http_request_header_parser_top.sv
// Top level of the HTTP request header parser.
// Depends on hrp_pkg, hrp_front and hrp_back.
//
//  channel | dir | tdata                             | tuser            | tlast
//  in_     | in  | payload_byte                      | first_byte       | last_byte
//  out_    | out | span_start, span_end, body_offset | kind,tpe,st,post | last_of_run
//
// One byte per cycle while the queue has room: the front parses in the cycle of acceptance.
// A byte yielding two results occupies the output for two beats.
// The two-entry queue lets input run on while output stalls.
// Reset: synchronous, active low; no clearing pass.
module http_request_header_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] payload_byte
  input  logic        in_tuser,   // [0] first_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] span_start [31:16] span_end [47:32] body_offset
  output logic [8:0]  out_tuser,  // [2:0] item_kind [3] to_payload_end [7:4] status [8] is_post
  output logic        out_tlast   // last_of_run
);
  import hrp_pkg::*;

  logic  q_valid, q_ready;
  cmd_t  q_cmd;
  res_t  res;

  hrp_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .byte_i(in_tdata), .first_i(in_tuser), .last_i(in_tlast),
    .q_ready, .q_valid, .q_cmd
  );

  hrp_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .out_tvalid, .out_tready, .res_o(res), .last_o(out_tlast)
  );

  assign out_tdata = {res.body_offset, res.span_end, res.span_start};
  assign out_tuser = {res.is_post, res.status, res.to_payload_end, res.item_kind};
endmodule

FILE: hdl/hrp_checker.sv
// Port-level checker for the header parser, bound to the top level.
// Depends on hrp_pkg and the macros header.
`include "http_request_header_parser_top_macros.svh"
module hrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [8:0]  out_tuser,
  input logic        out_tlast
);
  import hrp_pkg::*;

  // done beat always closes a run
  `HRP_ASSERT_IMP(a_done_last, out_tvalid && out_tuser[2:0] == K_DONE, out_tlast)
  // span beats carry no status
  `HRP_ASSERT_IMP(a_span_st, out_tvalid && out_tuser[2:0] != K_DONE, out_tuser[7:4] == ST_OK)
  // kind stays in range
  `HRP_ASSERT_IMP(a_kind, out_tvalid, out_tuser[2:0] <= K_DONE)
  // a non-last beat is followed by more
  `HRP_ASSERT_NEXT(a_more, out_tvalid && out_tready && !out_tlast, out_tvalid)
endmodule

bind http_request_header_parser_top hrp_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tuser, .out_tlast
);

FILE: tb/http_request_header_parser_scoreboard.sv
// Scoreboard of the HTTP request header parser testbench: byte-level parser
// model and the queue of expected result beats. Depends on hrp_pkg.
package hrp_tb_pkg;
  import hrp_pkg::*;

  typedef enum logic [3:0] {
    PS_START, PS_METHOD, PS_SP_URI, PS_URI, PS_AFTER_URI, PS_LINE_END,
    PS_HEAD, PS_NAME, PS_SP_VAL, PS_VAL, PS_IGNORE, PS_ALMOST
  } parse_state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] span_start;
    logic [15:0] span_end;
    logic        tpe;
    logic [3:0]  status;
    logic        is_post;
    logic [15:0] body;
    logic        last;
  } beat_t;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_SP = 8'd32;

  class hrp_scoreboard;
    parse_state_e pstate;
    logic [15:0]  pos, mark, uri_at;
    logic [47:0]  prefix;
    logic [2:0]   hkind;
    logic         post, active;
    beat_t        pending[$];
    int           errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      pstate = PS_START; pos = 0; mark = 0; uri_at = 0; prefix = 0;
      hkind = 3'd0; post = 0; active = 0;
    endfunction

    function bit prefix_is(string s, int n);
      for (int i = 0; i < n && i < 6; i++)
        if (prefix[8*i +: 8] != s[i]) return 0;
      return 1;
    endfunction

    function void add_char(logic [15:0] p, logic [7:0] ch);
      logic [15:0] k;
      k = p - mark;
      if (k < 6) prefix[8*k +: 8] = ch;
    endfunction

    function void push(logic [2:0] k, logic [15:0] s, logic [15:0] e, logic tpe,
                       logic [3:0] st, logic pst, logic [15:0] b);
      beat_t r;
      r = '{k, s, e, tpe, st, pst, b, 1'b0};
      pending.push_back(r);
    endfunction

    // Note one accepted input beat and queue the results it causes.
    function void note_byte(logic [7:0] ch, logic first, logic lastb);
      bit done;
      logic [3:0] st;
      logic [15:0] body, p, len;
      int n0;
      done = 0; st = ST_OK; body = 0; n0 = pending.size();
      if (first) begin
        clear();
        active = 1;
      end
      if (!active) return;
      p = pos;
      if (p >= MaxPayload) begin
        done = 1; st = ST_TOOLONG;
      end else if (ch == 0) begin
        done = 1; st = ST_EARLY;
      end else begin
        case (pstate)
          PS_START: begin
            mark = p;
            if (ch != CH_CR && ch != CH_LF) begin
              if (ch < "A" || ch > "Z") begin
                done = 1; st = ST_FIRST;
              end else begin
                prefix = {40'd0, ch}; pstate = PS_METHOD;
              end
            end
          end
          PS_METHOD: begin
            if (ch == CH_SP) begin
              len = p - mark;
              if (len == 3 && prefix_is("GET", 3)) pstate = PS_SP_URI;
              else if (len == 4 && prefix_is("POST", 4)) begin
                post = 1; pstate = PS_SP_URI;
              end else begin
                done = 1; st = ST_METHOD;
              end
            end else if (ch < "A" || ch > "Z") begin
              done = 1; st = ST_MCHAR;
            end else add_char(p, ch);
          end
          PS_SP_URI: begin
            if (ch == "/") begin
              uri_at = p; mark = p; pstate = PS_URI;
            end else if (ch != CH_SP) begin
              done = 1; st = ST_PREURI;
            end
          end
          PS_URI: begin
            if (ch == CH_SP) begin
              push(K_URI, uri_at, p - 16'd1, 0, 0, 0, 0);
              pstate = PS_AFTER_URI;
            end else if (ch == CH_CR) begin
              done = 1; st = ST_URICR;
            end else if (ch == CH_LF) begin
              done = 1; st = ST_URILF;
            end
          end
          PS_AFTER_URI: begin
            if (ch == CH_CR || ch == CH_LF) begin
              done = 1; st = ST_AFTURI;
            end else if (ch != CH_SP) pstate = (ch == "H") ? PS_LINE_END : PS_URI;
          end
          PS_LINE_END: if (ch == CH_LF) pstate = PS_HEAD;
          PS_HEAD: begin
            if (ch == CH_CR) pstate = PS_ALMOST;
            else if (ch == CH_LF) begin
              done = 1; st = ST_OK; body = p + 16'd1;
            end else if (ch != CH_SP) begin
              mark = p; prefix = {40'd0, ch}; pstate = PS_NAME;
            end
          end
          PS_NAME: begin
            if (ch != CH_SP && ch != ":") add_char(p, ch);
            else begin
              len = p - mark;
              pstate = PS_SP_VAL;
              if (len == 4 && prefix_is("Host", 4)) hkind = K_HOST;
              else if (len == 6 && prefix_is("Cookie", 6)) begin
                hkind = K_COOKIE;
                push(K_COOKIE, p + 16'd1, 0, 1, 0, 0, 0);
              end else if (len == 7 && prefix_is("Refer", 5)) hkind = K_REF;
              else if (len == 10 && prefix_is("User-", 5)) hkind = K_UA;
              else if (len == 14 && prefix_is("Conte", 5)) hkind = K_CLEN;
              else pstate = PS_IGNORE;
            end
          end
          PS_SP_VAL: begin
            if (ch != ":" && ch != CH_SP) begin
              mark = p; pstate = PS_VAL;
            end
          end
          PS_VAL: begin
            if (ch == CH_CR) begin
              if (hkind >= K_HOST && hkind <= K_CLEN)
                push(hkind, mark, p - 16'd1, 0, 0, 0, 0);
              else begin
                done = 1; st = ST_NOKIND;
              end
            end else if (ch == CH_LF) pstate = PS_HEAD;
          end
          PS_IGNORE: if (ch == CH_LF) pstate = PS_HEAD;
          PS_ALMOST: begin
            if (ch == CH_LF) begin
              done = 1; st = ST_OK; body = p + 16'd1;
            end else if (ch != CH_CR) begin
              done = 1; st = ST_BLANK;
            end
          end
          default: begin
            done = 1; st = ST_NOKIND;
          end
        endcase
        pos = p + 16'd1;
      end
      if (!done && lastb) begin
        done = 1; st = ST_EARLY;
      end
      if (done) begin
        push(K_DONE, 0, 0, 0, st, post, (st == ST_OK) ? body : 16'd0);
        active = 0; pstate = PS_START;
      end
      if (pending.size() > n0) pending[pending.size()-1].last = 1;
    endfunction

    task report(string what, beat_t got, beat_t exp);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, exp);
    endtask

    // Compare one result beat with the oldest expectation.
    task check_beat(logic [47:0] data, logic [8:0] user, logic lastb);
      beat_t got, exp;
      got = '{user[2:0], data[15:0], data[31:16], user[3], user[7:4], user[8],
              data[47:32], lastb};
      if (pending.size() == 0) begin
        report("unexpected beat", got, got);
        return;
      end
      exp = pending.pop_front();
      if (got.kind != exp.kind) report("item_kind", got, exp);
      if (got.span_start != exp.span_start) report("span_start", got, exp);
      if (got.span_end != exp.span_end) report("span_end", got, exp);
      if (got.tpe != exp.tpe) report("to_payload_end", got, exp);
      if (got.status != exp.status) report("status", got, exp);
      if (got.is_post != exp.is_post) report("is_post", got, exp);
      if (got.body != exp.body) report("body_offset", got, exp);
      if (got.last != exp.last) report("last_of_run", got, exp);
    endtask
  endclass
endpackage

FILE: tb/testbench.sv
// Top of the HTTP request header parser testbench: clock, reset, byte
// stream driver and result sink. Depends on hrp_pkg and hrp_tb_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hrp_pkg::*;
  import hrp_tb_pkg::*;

  localparam int IdleLimit = 20000;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tuser = 0, in_tlast = 0, out_tready = 0;
  logic [7:0] in_tdata = 0;
  logic in_tready, out_tvalid, out_tlast;
  logic [47:0] out_tdata;
  logic [8:0] out_tuser;

  hrp_scoreboard sb = new();
  bit calm = 0, hold_sink = 0;
  int idle_cycles = 0;
  byte unsigned pkt[$];

  http_request_header_parser_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Check every result beat and count cycles without progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser, out_tlast);
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tuser, in_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (!in_tvalid && sb.pending.size() == 0)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Sink side: random stall bursts, plus a long hold-off on request.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_sink) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        hold_sink = 0;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 14);
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
    end
  end

  // Offer one byte and hold it until accepted.
  task automatic send_byte(logic [7:0] b, logic first, logic lastb);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= b; in_tuser <= first; in_tlast <= lastb;
    @(posedge clk iff in_tready);
  endtask

  task automatic send_pkt(bit mark_last);
    for (int i = 0; i < pkt.size(); i++)
      send_byte(pkt[i], i == 0, mark_last && i == pkt.size() - 1);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
  endtask

  function automatic string rnd_word(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(97, 122)))};
    return s;
  endfunction

  // Build a mostly well-formed request with random content and faults.
  task automatic build_request();
    string names[7];
    int nh;
    names = '{"Host", "Cookie", "Referer", "User-Agent", "Content-Length",
              "X-Misc", "Accept"};
    pkt.delete();
    add_str($urandom_range(0, 1) ? "GET" : "POST");
    add_str(" /");
    add_str(rnd_word($urandom_range(0, 6)));
    add_str(" HTTP/1.1\r\n");
    nh = $urandom_range(0, 4);
    for (int h = 0; h < nh; h++) begin
      add_str(names[$urandom_range(0, 6)]);
      add_str($urandom_range(0, 1) ? ": " : ":");
      add_str(rnd_word($urandom_range(1, 5)));
      add_str("\r\n");
    end
    add_str("\r\n");
    // Corrupt a few requests: random byte or truncation.
    if ($urandom_range(0, 4) == 0)
      pkt[$urandom_range(0, pkt.size() - 1)] = $urandom_range(0, 255);
    if ($urandom_range(0, 5) == 0) pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
  endtask

  task automatic wait_drain();
    in_tvalid <= 0;
    @(posedge clk iff sb.pending.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    string directed[$];
    int sent;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed requests: full headers, many error and special cases.
    directed = '{
      "POST /a HTTP/1.1\r\nHost: h\r\nUser-Agent: u\r\nReferer: r\r\nCookie: c\r\nContent-Length: 9\r\n\r\n",
      "GET / H\n\n", "a", "GEX / ", "GE1", "GET x", "GET /\r", "GET /\n",
      "GET / \r", "GET / x H\r\nZ\r\n\r\nq", "GET / H\nXyz: q\r\n\r\r\r\n",
      "\r\nGET / H\n\r\n", "GET / H\nCookie:\r\n\n"};
    foreach (directed[d]) begin
      pkt.delete();
      add_str(directed[d]);
      send_pkt(d % 2);
    end
    // NUL byte, last-byte end, idle bytes, restart mid-parse, 0xFF.
    send_byte(8'h47, 1, 0); send_byte(8'h00, 0, 0);
    send_byte(8'hFF, 0, 0); send_byte(8'h80, 0, 1);
    send_byte(8'h47, 1, 0); send_byte(8'h45, 0, 0);
    send_byte(8'h50, 1, 0); send_byte(8'h4F, 0, 1);
    wait_drain();

    // Random part; a long sink hold-off and a full drain partway.
    sent = 0;
    while (sent < 1250) begin
      if (sent > 400 && sent < 460) hold_sink = 1;
      if (sent > 700 && sent < 760) wait_drain();
      if (sent > 1100) calm = 1;
      if ($urandom_range(0, 9) == 0) begin
        pkt.delete();
        repeat ($urandom_range(1, 8)) pkt.push_back($urandom_range(0, 255));
        for (int i = 0; i < pkt.size(); i++)
          send_byte(pkt[i], i == 0 ? $urandom_range(0, 1) : 0, $urandom_range(0, 1));
      end else begin
        build_request();
        send_pkt($urandom_range(0, 1));
      end
      sent += pkt.size();
    end
    in_tvalid <= 0;

    fork
      @(posedge clk iff sb.pending.size() == 0);
      begin
        repeat (100000) @(posedge clk);
        $display("TB_ERROR");
        $finish;
      end
    join_any
    disable fork;
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
